// ===== hdl/tgis_pkg.sv =====
// tgis_pkg: shared constants and types for the tile grid statistics block
// no dependencies
package tgis_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int MAX_GRID_COLS_DEF = 16;
    localparam int MAX_GRID_ROWS_DEF = 16;

    localparam int SUM_W  = 32;
    localparam int SQ_W   = 40;
    localparam int CNT_W  = 25;
    localparam int ACC_W  = SUM_W + SQ_W + 3 * CNT_W;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GCOLS  = 3'd2;
    localparam logic [2:0] REG_GROWS  = 3'd3;
    localparam logic [2:0] REG_DARK   = 3'd4;
    localparam logic [2:0] REG_BRIGHT = 3'd5;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [CNT_W-1:0] dark;
        logic [CNT_W-1:0] bright;
        logic [CNT_W-1:0] cnt;
    } acc_t;

    // request from the front end to the result unit
    typedef struct packed {
        logic       err;
        logic       last;
        logic [3:0] row;
        logic [3:0] col;
        acc_t       acc;
    } job_t;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] mean;
        logic [14:0] sd;
        logic [15:0] dark;
        logic [15:0] bright;
        logic        err;
        logic        last;
    } res_t;

endpackage

// ===== hdl/tgis_ram.sv =====
// tgis_ram: generic single-port-write, single-read synchronous ram
// registered read; no dependencies
module tgis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/tgis_divider.sv =====
// tgis_divider: restoring divider, one quotient bit per cycle
// depends on tgis_pkg
module tgis_divider import tgis_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 25,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);
    localparam int CW = $clog2(QW + 1);
    logic [NW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] n_reg;
    logic          busy_reg;
    logic [NW:0]   trial;
    logic [NW:0]   shd;
    logic [CW-1:0] bi;

    // quotient known to fit in QW bits, so numerator compared against d<<bit
    assign bi    = n_reg - CW'(1);
    assign shd   = (NW+1)'(d_reg) << bi;
    assign trial = {1'b0, rem_reg} - shd;
    assign quot  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= num;
                d_reg    <= den;
                q_reg    <= '0;
                n_reg    <= CW'(QW);
            end
            else if (busy_reg)
            begin
                if (!trial[NW])
                begin
                    rem_reg   <= trial[NW-1:0];
                    q_reg[bi] <= 1'b1;
                end
                n_reg <= bi;
                if (bi == '0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/tgis_result.sv =====
// tgis_result: turns one tile's sums into mean, deviation and fractions
// uses a shared divider; depends on tgis_pkg and tgis_divider
module tgis_result import tgis_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_DIFF, S_MEAN, S_DARK, S_BRIGHT,
        S_SQRT, S_SQCMP, S_OUT
    } state_t;

    state_t state_reg;
    job_t   job_reg;
    res_t   res_reg;
    logic   rv_reg;
    logic [79:0] a_reg, b_reg;
    logic [79:0] r_reg;
    logic [14:0] q_reg;
    logic [3:0]  bit_reg;
    logic [49:0] nn_reg;
    logic [31:0] t_reg;
    logic [63:0] tt_reg;
    logic [79:0] prod_reg;
    logic [1:0]  ph_reg;

    logic          dstart;
    logic [47:0]   dnum;
    logic          ddone;
    logic [16:0]   dq;
    logic [15:0]   sat16;
    logic [14:0]   cand;
    logic [31:0]   tnext;

    tgis_divider #(.NW(48), .DW(CNT_W), .QW(17)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(job_reg.acc.cnt),
        .done(ddone), .quot(dq)
    );

    assign sat16     = dq[16] ? 16'hFFFF : dq[15:0];
    assign job_ready = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign cand      = q_reg | (15'd1 << bit_reg);
    assign tnext     = {16'd0, cand, 1'b0} - 32'd1;

    always_comb
    begin
        dstart = 1'b0;
        dnum   = '0;
        unique case (state_reg)
            S_MUL1:
            begin
                dstart = 1'b1;
                dnum   = {job_reg.acc.sum[39-8:0], 8'd0} + 48'(job_reg.acc.cnt >> 1);
            end
            S_MEAN:
            begin
                dstart = ddone;
                dnum   = {7'd0, job_reg.acc.dark, 16'd0} + 48'(job_reg.acc.cnt >> 1);
            end
            S_DARK:
            begin
                dstart = ddone;
                dnum   = {7'd0, job_reg.acc.bright, 16'd0} + 48'(job_reg.acc.cnt >> 1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (rv_reg && res_ready)
            begin
                rv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !rv_reg)
                    begin
                        job_reg <= job;
                        res_reg <= '{row: job.row, col: job.col, mean: '0, sd: '0,
                                     dark: '0, bright: '0, err: job.err, last: job.last};
                        if (job.err || job.acc.cnt == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_MUL1;
                        end
                    end
                end
                S_MUL1:
                begin
                    // n*sumsq: 25x40 split into two 25x20 pieces
                    a_reg     <= 80'(job_reg.acc.cnt * job_reg.acc.sq[19:0]);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    a_reg     <= a_reg + (80'(job_reg.acc.cnt * job_reg.acc.sq[39:20]) << 20);
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    b_reg     <= 80'(job_reg.acc.sum * job_reg.acc.sum);
                    nn_reg    <= 50'(job_reg.acc.cnt * job_reg.acc.cnt);
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    r_reg     <= (a_reg > b_reg) ? ((a_reg - b_reg) << 18) : '0;
                    state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    if (ddone)
                    begin
                        res_reg.mean <= sat16;
                        state_reg    <= S_DARK;
                    end
                end
                S_DARK:
                begin
                    if (ddone)
                    begin
                        res_reg.dark <= sat16;
                        state_reg    <= S_BRIGHT;
                    end
                end
                S_BRIGHT:
                begin
                    if (ddone)
                    begin
                        res_reg.bright <= sat16;
                        q_reg     <= '0;
                        bit_reg   <= 4'd14;
                        ph_reg    <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // one candidate bit per pass: t*t, then (t*t)*n*n in pieces
                    unique case (ph_reg)
                        2'd0:
                        begin
                            t_reg  <= tnext;
                            ph_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            tt_reg <= t_reg * t_reg;
                            ph_reg <= 2'd2;
                        end
                        2'd2:
                        begin
                            prod_reg <= 80'(tt_reg[31:0] * nn_reg[24:0]);
                            ph_reg   <= 2'd3;
                        end
                        default:
                        begin
                            prod_reg  <= prod_reg + (80'(tt_reg[31:0] * nn_reg[49:25]) << 25);
                            state_reg <= S_SQCMP;
                        end
                    endcase
                end
                S_SQCMP:
                begin
                    if (prod_reg <= r_reg)
                    begin
                        q_reg <= cand;
                    end
                    ph_reg <= '0;
                    if (bit_reg == '0)
                    begin
                        res_reg.sd <= (prod_reg <= r_reg) ? cand : q_reg;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= S_SQRT;
                    end
                end
                default:
                begin
                    if (!rv_reg)
                    begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !res_ready |=> rv_reg && $stable(res_reg))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready)
        else $error("result unit took two jobs");
    assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && res_reg.err |-> res_reg.mean == '0 && res_reg.sd == '0)
        else $error("error result carries data");
endmodule

// ===== hdl/tgis_front.sv =====
// tgis_front: pixel position tracking and per-column accumulation in ram
// depends on tgis_pkg and tgis_ram
module tgis_front import tgis_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int MAX_GRID_COLS = MAX_GRID_COLS_DEF,
    parameter int MAX_GRID_ROWS = MAX_GRID_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        frame_start,
    input  logic [12:0] cfg_w,
    input  logic [12:0] cfg_h,
    input  logic [4:0]  cfg_gc,
    input  logic [4:0]  cfg_gr,
    input  logic [7:0]  cfg_dark,
    input  logic [7:0]  cfg_bright,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    localparam int CA = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int GW = $clog2(MAX_GRID_ROWS + 1) > $clog2(MAX_GRID_COLS + 1) ?
                        $clog2(MAX_GRID_ROWS + 1) : $clog2(MAX_GRID_COLS + 1);
    localparam int EXW = XW + GW + 1;
    localparam int EYW = YW + GW + 1;

    typedef enum logic [2:0] { S_RUN, S_RD, S_UPD, S_FLRD, S_FLWAIT, S_FLSEND, S_ERR } state_t;

    state_t        state_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [GW-1:0] tc_reg, tr_reg, fc_reg, gcl_reg;
    logic [CA-1:0] addr_reg;
    logic [7:0]    pix_reg;
    logic          close_reg;
    logic [MAX_GRID_COLS-1:0] vld_reg;
    logic          ram_we;
    logic [CA-1:0] ram_waddr, ram_raddr;
    acc_t          ram_wdata, ram_rdata, cur;
    logic [XW-1:0] w;
    logic [YW-1:0] h;
    logic [GW-1:0] gc, gr, tcc, trc;
    logic          gerr;
    logic [EXW-1:0] ex_lhs, ex_rhs;
    logic [EYW-1:0] ey_lhs, ey_rhs;
    logic           col_step, row_edge;
    logic           take, fs_now;

    tgis_ram #(.WIDTH(ACC_W), .DEPTH(1 << CA)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_comb
    begin
        w  = (cfg_w == '0) ? XW'(1) : (32'(cfg_w) > MAX_WIDTH ? XW'(MAX_WIDTH) : XW'(cfg_w));
        h  = (cfg_h == '0) ? YW'(1) : (32'(cfg_h) > MAX_HEIGHT ? YW'(MAX_HEIGHT) : YW'(cfg_h));
        gc = (cfg_gc == '0) ? GW'(1) :
             (32'(cfg_gc) > MAX_GRID_COLS ? GW'(MAX_GRID_COLS) : GW'(cfg_gc));
        gr = (cfg_gr == '0) ? GW'(1) :
             (32'(cfg_gr) > MAX_GRID_ROWS ? GW'(MAX_GRID_ROWS) : GW'(cfg_gr));
        gerr = (32'(gc) > 32'(w)) || (32'(gr) > 32'(h));
        tcc  = (tc_reg < gc) ? tc_reg : gc - GW'(1);
        trc  = (tr_reg < gr) ? tr_reg : gr - GW'(1);
        // tile edges without division: p >= floor(e*size/g) iff (p+1)*g > e*size
        ex_lhs   = (EXW'(x_reg) + EXW'(2)) * EXW'(gc);
        ex_rhs   = EXW'(tcc + GW'(1)) * EXW'(w);
        col_step = (ex_lhs > ex_rhs);
        ey_lhs   = (EYW'(y_reg) + EYW'(2)) * EYW'(gr);
        ey_rhs   = EYW'(trc + GW'(1)) * EYW'(h);
        row_edge = (ey_lhs > ey_rhs);
        cur = vld_reg[addr_reg] ? ram_rdata : '0;
    end

    assign in_ready = (state_reg == S_RUN);
    assign take     = in_valid && in_ready;
    assign fs_now   = frame_start;
    assign job_valid = (state_reg == S_FLSEND) || (state_reg == S_ERR);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_raddr = addr_reg;
        ram_wdata = cur;
        job       = '0;
        unique case (state_reg)
            S_RUN:
            begin
                ram_raddr = CA'(fs_now ? GW'(0) : tcc);
            end
            S_UPD:
            begin
                ram_we         = 1'b1;
                ram_wdata.sum  = cur.sum + SUM_W'(pix_reg);
                ram_wdata.sq   = cur.sq + SQ_W'(pix_reg * pix_reg);
                ram_wdata.cnt  = cur.cnt + CNT_W'(1);
                ram_wdata.dark = cur.dark + CNT_W'(pix_reg < cfg_dark);
                ram_wdata.bright = cur.bright + CNT_W'(pix_reg > cfg_bright);
            end
            S_FLRD, S_FLWAIT:
            begin
                ram_raddr = CA'(fc_reg);
            end
            S_FLSEND:
            begin
                job.row  = 4'(trc);
                job.col  = 4'(fc_reg);
                job.last = (fc_reg + GW'(1) >= gcl_reg);
                job.acc  = vld_reg[CA'(fc_reg)] ? ram_rdata : '0;
                ram_raddr = CA'(fc_reg);
            end
            S_ERR:
            begin
                job.err  = 1'b1;
                job.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            x_reg     <= '0;
            y_reg     <= '0;
            tc_reg    <= '0;
            tr_reg    <= '0;
            fc_reg    <= '0;
            gcl_reg   <= '0;
            addr_reg  <= '0;
            close_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_RUN:
                begin
                    if (take)
                    begin
                        logic [XW-1:0] xx;
                        logic [YW-1:0] yy;
                        logic [GW-1:0] t0, r0;
                        xx = fs_now ? '0 : x_reg;
                        yy = fs_now ? '0 : y_reg;
                        t0 = fs_now ? '0 : tcc;
                        r0 = fs_now ? '0 : trc;
                        if (fs_now)
                        begin
                            vld_reg <= '0;
                        end
                        pix_reg  <= pixel;
                        addr_reg <= CA'(t0);
                        if (gerr)
                        begin
                            tc_reg <= '0;
                            tr_reg <= '0;
                            if (32'(xx) + 1 >= 32'(w))
                            begin
                                x_reg <= '0;
                                y_reg <= (32'(yy) + 1 >= 32'(h)) ? '0 : yy + YW'(1);
                            end
                            else
                            begin
                                x_reg <= xx + XW'(1);
                            end
                            if (xx == '0 && yy == '0)
                            begin
                                state_reg <= S_ERR;
                            end
                        end
                        else
                        begin
                            tc_reg    <= t0;
                            tr_reg    <= r0;
                            x_reg     <= xx;
                            y_reg     <= yy;
                            state_reg <= fs_now ? S_RD : S_UPD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    vld_reg[addr_reg] <= 1'b1;
                    if (32'(x_reg) + 1 >= 32'(w))
                    begin
                        x_reg  <= '0;
                        tc_reg <= '0;
                        if (32'(y_reg) + 1 >= 32'(h) || row_edge)
                        begin
                            close_reg <= (32'(y_reg) + 1 >= 32'(h));
                            fc_reg    <= '0;
                            gcl_reg   <= gc;
                            state_reg <= S_FLRD;
                        end
                        else
                        begin
                            y_reg     <= y_reg + YW'(1);
                            state_reg <= S_RUN;
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + XW'(1);
                        if (tcc + GW'(1) < gc && col_step)
                        begin
                            tc_reg <= tcc + GW'(1);
                        end
                        state_reg <= S_RUN;
                    end
                end
                S_FLRD:
                begin
                    state_reg <= S_FLWAIT;
                end
                S_FLWAIT:
                begin
                    state_reg <= S_FLSEND;
                end
                S_FLSEND:
                begin
                    if (job_ready)
                    begin
                        vld_reg[CA'(fc_reg)] <= 1'b0;
                        if (fc_reg + GW'(1) >= gcl_reg)
                        begin
                            if (close_reg)
                            begin
                                y_reg  <= '0;
                                tr_reg <= '0;
                            end
                            else
                            begin
                                y_reg <= y_reg + YW'(1);
                                if (trc + GW'(1) < gr)
                                begin
                                    tr_reg <= trc + GW'(1);
                                end
                            end
                            state_reg <= S_RUN;
                        end
                        else
                        begin
                            fc_reg    <= fc_reg + GW'(1);
                            state_reg <= S_FLRD;
                        end
                    end
                end
                default:
                begin
                    if (job_ready)
                    begin
                        state_reg <= S_RUN;
                    end
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_UPD)
        else $error("ram written outside update");
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !in_ready)
        else $error("pixel taken during flush");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLSEND && job_ready && fc_reg + GW'(1) < gcl_reg |=> state_reg == S_FLRD)
        else $error("flush skipped a column");
endmodule

// ===== hdl/tile_grid_intensity_statistics.sv =====
// tile_grid_intensity_statistics: top level, config registers, front end and result unit
// depends on tgis_pkg, tgis_front, tgis_result
//
// Grayscale pixels enter in raster order; per-tile-column sums live in a small
// synchronous ram updated by read-modify-write. A pixel passes a run and an update state
// (and a read state between them on a frame start; only the run state while the grid
// is larger than the image). When a row closes a tile row, each tile column is read out
// and handed to a result unit whose shared bit-serial divider (three quotients) and
// 15-step root search process each tile; pixels stall during that flush. The ram needs
// no clearing pass: one valid bit per column marks written entries.
module tile_grid_intensity_statistics import tgis_pkg::*; #(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = MAX_HEIGHT_DEF,
    parameter int MAX_GRID_COLS = MAX_GRID_COLS_DEF,
    parameter int MAX_GRID_ROWS = MAX_GRID_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // tile_row, tile_col, mean_q8, std_dev_q8, dark_fraction,
                                   // saturated_fraction, grid_error
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    logic [12:0] w_reg, h_reg;
    logic [4:0]  gc_reg, gr_reg;
    logic [7:0]  dk_reg, br_reg;
    logic        jv, jr;
    job_t        jb;
    res_t        rs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 13'd640;
            h_reg  <= 13'd480;
            gc_reg <= 5'd4;
            gr_reg <= 5'd4;
            dk_reg <= 8'd20;
            br_reg <= 8'd245;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  w_reg  <= cfg_data;
                REG_HEIGHT: h_reg  <= cfg_data;
                REG_GCOLS:  gc_reg <= cfg_data[4:0];
                REG_GROWS:  gr_reg <= cfg_data[4:0];
                REG_DARK:   dk_reg <= cfg_data[7:0];
                REG_BRIGHT: br_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tgis_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_GRID_COLS(MAX_GRID_COLS), .MAX_GRID_ROWS(MAX_GRID_ROWS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .pixel(s_tdata), .frame_start(s_tuser),
        .cfg_w(w_reg), .cfg_h(h_reg), .cfg_gc(gc_reg), .cfg_gr(gr_reg),
        .cfg_dark(dk_reg), .cfg_bright(br_reg),
        .job_valid(jv), .job_ready(jr), .job(jb)
    );

    tgis_result u_result (
        .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(rs)
    );

    assign m_tdata = {rs.err, rs.bright, rs.dark, rs.sd, rs.mean, rs.col, rs.row};
    assign m_tlast = rs.last;
endmodule
